/* rtl/core/radix_literal_parser_unit_defines.svh */
// assertion macros for the radix literal parser
`ifndef RADIX_LITERAL_PARSER_UNIT_DEFINES_SVH
`define RADIX_LITERAL_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RLP_ASSERT_IMPLY(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("radix literal parser: same-cycle check failed");

// next-cycle implication, checked outside reset
`define RLP_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("radix literal parser: next-cycle check failed");

`endif

/* rtl/core/rlp_pkg.sv */
// shared types, constants and helpers for the radix literal parser
package rlp_pkg;

  localparam int CHAR_W     = 8;
  localparam int RADIX_W    = 5;
  localparam int VALUE_W    = 64;
  localparam int OUT_DATA_W = 72;
  localparam int POS_W      = 2;

  typedef enum logic [1:0] {
    RC_DEC = 2'd0,
    RC_OCT = 2'd1,
    RC_HEX = 2'd2,
    RC_BIN = 2'd3
  } radix_code_t;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOW_F = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LOW_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LOW_B = 8'h62;

  localparam logic [POS_W-1:0] POS_FIRST  = 2'd0;
  localparam logic [POS_W-1:0] POS_SECOND = 2'd1;
  localparam logic [POS_W-1:0] POS_REST   = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_TWO     = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_EIGHT   = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_TEN     = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_SIXTEEN = 5'd16;

  function automatic logic [RADIX_W-1:0] radix_number(input radix_code_t rc);
    logic [RADIX_W-1:0] r;
    case (rc)
      RC_OCT:  r = RADIX_EIGHT;
      RC_HEX:  r = RADIX_SIXTEEN;
      RC_BIN:  r = RADIX_TWO;
      default: r = RADIX_TEN;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/radix_literal_parser_unit.sv */
// Integer literal parser with radix prefix. One character of a token is taken per item on the
// slave stream, with tlast on the final character; a new character is accepted every cycle.
// State is updated as each character arrives, and the result for a token leaves the output
// register in the cycle after its last character is accepted. The longest path is the 64-bit
// times-ten add (two shifted copies plus the digit) feeding the accumulator register.
// A single result register sits between the sides. While a finished result is held and the
// master side is stalled, the slave side is held off for every character, last or not.
`include "radix_literal_parser_unit_defines.svh"

module radix_literal_parser_unit
  import rlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [CHAR_W-1:0]     s_axis_tdata,   // [7:0] char_code
  input  logic                  s_axis_tlast,   // is_last
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [4:0] radix, [68:5] value, [71:69] zero
  output logic                  m_axis_tuser    // is_valid
);

  logic [POS_W-1:0]   pos;
  radix_code_t        rc;
  logic               still_valid;
  logic               first_was_zero;
  logic [VALUE_W-1:0] acc;

  logic [POS_W-1:0]   pos_next;
  radix_code_t        rc_next;
  logic               still_valid_next;
  logic               first_was_zero_next;
  logic [VALUE_W-1:0] acc_next;

  logic               res_is_valid;
  logic [RADIX_W-1:0] res_radix;
  logic [VALUE_W-1:0] res_value;

  logic               s_fire;
  logic               is_dec;
  logic               is_hex_letter;
  logic [3:0]         dig;
  logic               digit_ok;
  logic [VALUE_W-1:0] acc_times_ten;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    is_dec        = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
    is_hex_letter = (s_axis_tdata >= CH_LOW_A) && (s_axis_tdata <= CH_LOW_F);
    // ascii digits carry the value in the low nibble; for lowercase letters it is the low nibble plus nine
    dig           = is_dec ? s_axis_tdata[3:0] : s_axis_tdata[3:0] + 4'd9;
    acc_times_ten = {acc[VALUE_W-4:0], 3'b000} + {acc[VALUE_W-2:0], 1'b0}
                    + {{(VALUE_W-4){1'b0}}, dig};
    case (rc)
      RC_OCT:  digit_ok = is_dec && !dig[3];
      RC_HEX:  digit_ok = is_dec || is_hex_letter;
      RC_BIN:  digit_ok = is_dec && (dig[3:1] == 3'd0);
      default: digit_ok = is_dec;
    endcase

    pos_next            = (pos == POS_REST) ? POS_REST : pos + 2'd1;
    rc_next             = rc;
    still_valid_next    = still_valid;
    first_was_zero_next = first_was_zero;
    acc_next            = acc;

    if (still_valid) begin
      case (pos)
        POS_FIRST: begin
          if (is_dec) begin
            first_was_zero_next = (s_axis_tdata == CH_ZERO);
            acc_next            = {{(VALUE_W-4){1'b0}}, dig};
            rc_next             = RC_DEC;
          end else begin
            still_valid_next = 1'b0;
          end
        end
        POS_SECOND: begin
          if (is_dec) begin
            if (first_was_zero) begin
              rc_next = RC_OCT;
              if (dig[3]) still_valid_next = 1'b0;
              else acc_next = {{(VALUE_W-4){1'b0}}, dig};
            end else begin
              acc_next = acc_times_ten;
            end
          end else if (first_was_zero && s_axis_tdata == CH_LOW_X) begin
            rc_next  = RC_HEX;
            acc_next = '0;
          end else if (first_was_zero && s_axis_tdata == CH_LOW_B) begin
            rc_next  = RC_BIN;
            acc_next = '0;
          end else begin
            still_valid_next = 1'b0;
          end
        end
        default: begin
          if (!digit_ok) begin
            still_valid_next = 1'b0;
          end else begin
            case (rc)
              RC_HEX:  acc_next = {acc[VALUE_W-5:0], dig};
              RC_OCT:  acc_next = {acc[VALUE_W-4:0], dig[2:0]};
              RC_BIN:  acc_next = {acc[VALUE_W-2:0], dig[0]};
              default: acc_next = acc_times_ten;
            endcase
          end
        end
      endcase
    end

    res_is_valid = still_valid_next;
    res_radix    = still_valid_next ? radix_number(rc_next) : '0;
    res_value    = still_valid_next ? acc_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= POS_FIRST;
      rc             <= RC_DEC;
      still_valid    <= 1'b1;
      first_was_zero <= 1'b0;
      acc            <= '0;
    end else if (s_fire) begin
      if (s_axis_tlast) begin
        // token done, back to the start-of-token state
        pos            <= POS_FIRST;
        rc             <= RC_DEC;
        still_valid    <= 1'b1;
        first_was_zero <= 1'b0;
        acc            <= '0;
      end else begin
        pos            <= pos_next;
        rc             <= rc_next;
        still_valid    <= still_valid_next;
        first_was_zero <= first_was_zero_next;
        acc            <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_fire && s_axis_tlast) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_axis_tlast) begin
      m_axis_tdata <= {3'b000, res_value, res_radix};
      m_axis_tuser <= res_is_valid;
    end
  end

  `RLP_ASSERT_IMPLY(a_invalid_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
  `RLP_ASSERT_IMPLY(a_radix_legal, m_axis_tvalid && m_axis_tuser,
    m_axis_tdata[RADIX_W-1:0] == RADIX_TWO || m_axis_tdata[RADIX_W-1:0] == RADIX_EIGHT ||
    m_axis_tdata[RADIX_W-1:0] == RADIX_TEN || m_axis_tdata[RADIX_W-1:0] == RADIX_SIXTEEN)
  `RLP_ASSERT_NEXT(a_last_gives_result, s_fire && s_axis_tlast,
    m_axis_tvalid && pos == POS_FIRST && still_valid)
  `RLP_ASSERT_NEXT(a_pos_saturates, s_fire && !s_axis_tlast && pos == POS_REST,
    pos == POS_REST)

endmodule
